FILE: hw/rtl/hrbe_pkg.sv
`default_nettype none
package hrbe_pkg;

	typedef enum logic [3:0] {
		PH_STATUS       = 4'd0,
		PH_STATUS_LF    = 4'd1,
		PH_HDR_START    = 4'd2,
		PH_KEY          = 4'd3,
		PH_VAL_SKIP     = 4'd4,
		PH_VALUE        = 4'd5,
		PH_VAL_LF       = 4'd6,
		PH_HDR_END_LF   = 4'd7,
		PH_BODY         = 4'd8,
		PH_CHUNK_SIZE   = 4'd9,
		PH_CHUNK_EXT    = 4'd10,
		PH_CHUNK_EXT_LF = 4'd11,
		PH_CHUNK_DATA   = 4'd12,
		PH_CHUNK_TRAIL1 = 4'd13,
		PH_CHUNK_TRAIL2 = 4'd14,
		PH_DONE         = 4'd15
	} phase_t;

	localparam logic [2:0] KIND_BODY     = 3'd0;
	localparam logic [2:0] KIND_OK       = 3'd1;
	localparam logic [2:0] KIND_NO_BODY  = 3'd2;
	localparam logic [2:0] KIND_FORMAT   = 3'd3;
	localparam logic [2:0] KIND_STATUS   = 3'd4;
	localparam logic [2:0] KIND_OVERFLOW = 3'd5;

	localparam logic [9:0]  STATUS_RESET = 10'd200;
	localparam logic [30:0] LEN_SAT      = 31'h7FFF_FFFF;

	typedef struct packed {
		logic [2:0]  kind;
		logic [7:0]  body_byte;
		logic [9:0]  status_code;
		logic [12:0] body_count;
		logic        last;
	} result_t;

	function automatic logic [7:0] to_lower(input logic [7:0] c);
		return (c >= 8'h41 && c <= 8'h5A) ? c + 8'd32 : c;
	endfunction

	function automatic logic [7:0] key_cl(input logic [4:0] i);
		case (i)
			5'd0: return "c";  5'd1: return "o";  5'd2: return "n";  5'd3: return "t";
			5'd4: return "e";  5'd5: return "n";  5'd6: return "t";  5'd7: return "-";
			5'd8: return "l";  5'd9: return "e";  5'd10: return "n"; 5'd11: return "g";
			5'd12: return "t"; 5'd13: return "h";
			default: return 8'h00;
		endcase
	endfunction

	function automatic logic [7:0] key_te(input logic [4:0] i);
		case (i)
			5'd0: return "t";  5'd1: return "r";  5'd2: return "a";  5'd3: return "n";
			5'd4: return "s";  5'd5: return "f";  5'd6: return "e";  5'd7: return "r";
			5'd8: return "-";  5'd9: return "e";  5'd10: return "n"; 5'd11: return "c";
			5'd12: return "o"; 5'd13: return "d"; 5'd14: return "i"; 5'd15: return "n";
			5'd16: return "g";
			default: return 8'h00;
		endcase
	endfunction

	function automatic logic [7:0] word_chunked(input logic [2:0] i);
		case (i)
			3'd0: return "c"; 3'd1: return "h"; 3'd2: return "u"; 3'd3: return "n";
			3'd4: return "k"; 3'd5: return "e"; 3'd6: return "d";
			default: return 8'h00;
		endcase
	endfunction

endpackage
`default_nettype wire

FILE: hw/rtl/hrbe_parser.sv
`default_nettype none
module hrbe_parser #(
	parameter int MAX_BODY_BYTES = 4096
) (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                in_valid,
	input  wire logic [7:0]          c,
	input  wire logic                eor,
	input  wire logic [9:0]          accepted_status,
	output hrbe_pkg::result_t        res0,
	output logic                     res0_valid,
	output hrbe_pkg::result_t        res1,
	output logic                     res1_valid
);

	localparam int BW = $clog2(MAX_BODY_BYTES + 1);

	hrbe_pkg::phase_t phase_q, ph;
	logic [1:0]  space_q, sp;
	logic [9:0]  code_q, cv;
	logic [2:0]  digits_q, cd;
	logic        bad_q, cb;
	logic [4:0]  nidx_q, ni;
	logic [1:0]  nflags_q, nf;
	logic [2:0]  vidx_q, vi;
	logic        vchunk_q, vc;
	logic [30:0] clen_q, cl;
	logic        cmode_q, cm;
	logic [30:0] crem_q, cr;
	logic        hex_q, hx;
	logic [BW-1:0] bytes_q, bb;
	logic        seen_q, bs;
	logic [2:0]  err_q, ec;

	logic        ws, dec, hexok;
	logic [3:0]  hv, dv;
	logic [7:0]  lc;
	logic [9:0]  status_now, status_end;
	logic        emit;
	logic [2:0]  end_kind;
	logic [BW-1:0] bytes_next;

	always_comb begin
		lc  = hrbe_pkg::to_lower(c);
		ws  = (c == 8'h20) || (c >= 8'd9 && c <= 8'd13);
		dec = (c >= "0" && c <= "9");
		dv  = 4'(c - "0");
		hexok = dec || (lc >= "a" && lc <= "f");
		hv  = dec ? dv : 4'(lc - "a" + 8'd10);
	end

	always_comb begin
		ph = phase_q; sp = space_q; cv = code_q; cd = digits_q; cb = bad_q;
		ni = nidx_q; nf = nflags_q; vi = vidx_q; vc = vchunk_q; cl = clen_q;
		cm = cmode_q; cr = crem_q; hx = hex_q; bb = bytes_q; bs = seen_q; ec = err_q;
		emit = 1'b0;
		status_now = (digits_q == 3'd3 && !bad_q) ? code_q : 10'd0;

		if (phase_q == hrbe_pkg::PH_HDR_START && c != 8'h0D) begin
			ni = 5'd0; nf = 2'b11;
		end
		if (phase_q == hrbe_pkg::PH_BODY || phase_q == hrbe_pkg::PH_CHUNK_DATA) begin
			if (bytes_q >= BW'(MAX_BODY_BYTES)) begin
				ec = hrbe_pkg::KIND_OVERFLOW; ph = hrbe_pkg::PH_DONE;
			end else begin
				emit = 1'b1; bb = bytes_q + BW'(1); bs = 1'b1;
			end
		end

		unique case (phase_q) inside
			hrbe_pkg::PH_STATUS: begin
				if (c == 8'h0D) ph = hrbe_pkg::PH_STATUS_LF;
				else if (c == 8'h20) begin
					if (space_q < 2'd2) sp = space_q + 2'd1;
				end else if (space_q == 2'd1) begin
					if (dec) begin
						if (digits_q < 3'd3) cv = 10'(code_q * 10'd10 + 10'(dv));
						if (digits_q < 3'd4) cd = digits_q + 3'd1;
					end else cb = 1'b1;
				end
			end
			hrbe_pkg::PH_STATUS_LF: ph = hrbe_pkg::PH_HDR_START;
			hrbe_pkg::PH_HDR_START, hrbe_pkg::PH_KEY: begin
				if (phase_q == hrbe_pkg::PH_HDR_START && c == 8'h0D)
					ph = hrbe_pkg::PH_HDR_END_LF;
				else if (c == 8'h0D) begin
					ec = hrbe_pkg::KIND_FORMAT; ph = hrbe_pkg::PH_DONE;
				end else if (c == ":") begin
					nf[0] = nf[0] && ni == 5'd14;
					nf[1] = nf[1] && ni == 5'd17;
					vi = 3'd0; vc = 1'b1;
					if (nf[0]) cl = '0;
					ph = hrbe_pkg::PH_VAL_SKIP;
				end else begin
					ph = hrbe_pkg::PH_KEY;
					if (ni >= 5'd14 || lc != hrbe_pkg::key_cl(ni)) nf[0] = 1'b0;
					if (ni >= 5'd17 || lc != hrbe_pkg::key_te(ni)) nf[1] = 1'b0;
					if (ni < 5'd31) ni = ni + 5'd1;
				end
			end
			hrbe_pkg::PH_VAL_SKIP, hrbe_pkg::PH_VALUE: begin
				if (phase_q == hrbe_pkg::PH_VAL_SKIP && c == 8'h20) begin
				end else begin
					ph = hrbe_pkg::PH_VALUE;
					if (c == 8'h0D) begin
						if (nflags_q[1] && vchunk_q && vidx_q == 3'd7) cm = 1'b1;
						ph = hrbe_pkg::PH_VAL_LF;
					end else if (nflags_q[0]) begin
						if (vidx_q == 3'd0 && ws) begin
						end else if (vidx_q == 3'd0 && c == "+") vi = 3'd1;
						else if (vidx_q <= 3'd1 && dec) begin
							if (clen_q > hrbe_pkg::LEN_SAT / 31'd10 -
									((dv > 4'd7) ? 31'd1 : 31'd0))
								cl = hrbe_pkg::LEN_SAT;
							else cl = 31'(clen_q * 31'd10 + 31'(dv));
							vi = 3'd1;
						end else vi = 3'd2;
					end else if (nflags_q[1]) begin
						if (vidx_q < 3'd7 && lc == hrbe_pkg::word_chunked(vidx_q))
							vi = vidx_q + 3'd1;
						else vc = 1'b0;
					end
				end
			end
			hrbe_pkg::PH_VAL_LF: begin
				if (c == 8'h0A) ph = hrbe_pkg::PH_HDR_START;
				else begin ec = hrbe_pkg::KIND_FORMAT; ph = hrbe_pkg::PH_DONE; end
			end
			hrbe_pkg::PH_HDR_END_LF: begin
				if (c != 8'h0A) begin
					ec = hrbe_pkg::KIND_FORMAT; ph = hrbe_pkg::PH_DONE;
				end else if (space_q == 2'd0) begin
					ec = hrbe_pkg::KIND_FORMAT; ph = hrbe_pkg::PH_DONE;
				end else if (status_now == 10'd0 || status_now != accepted_status) begin
					ec = hrbe_pkg::KIND_STATUS; ph = hrbe_pkg::PH_DONE;
				end else if (cmode_q) begin
					ph = hrbe_pkg::PH_CHUNK_SIZE; hx = 1'b0; cr = '0;
				end else if (clen_q == '0) begin
					ec = hrbe_pkg::KIND_NO_BODY; ph = hrbe_pkg::PH_DONE;
				end else ph = hrbe_pkg::PH_BODY;
			end
			hrbe_pkg::PH_BODY: begin
				if (emit) begin
					cl = clen_q - 31'd1;
					if (clen_q == 31'd1) begin ec = hrbe_pkg::KIND_OK; ph = hrbe_pkg::PH_DONE; end
				end
			end
			hrbe_pkg::PH_CHUNK_SIZE: begin
				if (!hex_q) begin
					if (ws) begin
					end else if (!hexok) begin
						ec = seen_q ? hrbe_pkg::KIND_OK : hrbe_pkg::KIND_NO_BODY;
						ph = hrbe_pkg::PH_DONE;
					end else begin
						hx = 1'b1; cr = 31'(hv);
					end
				end else if (hexok) begin
					if (crem_q > ((hrbe_pkg::LEN_SAT - 31'(hv)) >> 4)) cr = hrbe_pkg::LEN_SAT;
					else cr = {crem_q[26:0], hv};
				end else if (crem_q == '0) begin
					ec = seen_q ? hrbe_pkg::KIND_OK : hrbe_pkg::KIND_NO_BODY;
					ph = hrbe_pkg::PH_DONE;
				end else ph = (c == 8'h0D) ? hrbe_pkg::PH_CHUNK_EXT_LF : hrbe_pkg::PH_CHUNK_EXT;
			end
			hrbe_pkg::PH_CHUNK_EXT: if (c == 8'h0D) ph = hrbe_pkg::PH_CHUNK_EXT_LF;
			hrbe_pkg::PH_CHUNK_EXT_LF: begin
				if (c == 8'h0A) ph = hrbe_pkg::PH_CHUNK_DATA;
				else if (c != 8'h0D) ph = hrbe_pkg::PH_CHUNK_EXT;
			end
			hrbe_pkg::PH_CHUNK_DATA: begin
				if (emit) begin
					cr = crem_q - 31'd1;
					if (crem_q == 31'd1) ph = hrbe_pkg::PH_CHUNK_TRAIL1;
				end
			end
			hrbe_pkg::PH_CHUNK_TRAIL1: ph = hrbe_pkg::PH_CHUNK_TRAIL2;
			hrbe_pkg::PH_CHUNK_TRAIL2: begin
				ph = hrbe_pkg::PH_CHUNK_SIZE; hx = 1'b0; cr = '0;
			end
			hrbe_pkg::PH_DONE: begin
			end
			default: begin
			end
		endcase

		bytes_next = bb;
		status_end = (cd == 3'd3 && !cb) ? cv : 10'd0;
		if (ec != 3'd0) end_kind = ec;
		else if (ph <= hrbe_pkg::PH_HDR_END_LF) end_kind = hrbe_pkg::KIND_FORMAT;
		else if (ph == hrbe_pkg::PH_BODY) end_kind = hrbe_pkg::KIND_OK;
		else end_kind = bs ? hrbe_pkg::KIND_OK : hrbe_pkg::KIND_NO_BODY;

		res0.kind        = emit ? hrbe_pkg::KIND_BODY : end_kind;
		res0.body_byte   = emit ? c : 8'd0;
		res0.status_code = status_now;
		res0.body_count  = 13'(bytes_next);
		res0.last        = !emit;
		res0_valid       = in_valid && (emit || eor);
		res1.kind        = end_kind;
		res1.body_byte   = 8'd0;
		res1.status_code = status_end;
		res1.body_count  = 13'(bytes_next);
		res1.last        = 1'b1;
		res1_valid       = in_valid && emit && eor;
		if (!emit) res0.status_code = status_end;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= hrbe_pkg::PH_STATUS; space_q <= '0; code_q <= '0; digits_q <= '0;
			bad_q <= 1'b0; nidx_q <= '0; nflags_q <= 2'b11; vidx_q <= '0; vchunk_q <= 1'b1;
			clen_q <= '0; cmode_q <= 1'b0; crem_q <= '0; hex_q <= 1'b0; bytes_q <= '0;
			seen_q <= 1'b0; err_q <= '0;
		end else if (in_valid) begin
			if (eor) begin
				phase_q <= hrbe_pkg::PH_STATUS; space_q <= '0; code_q <= '0; digits_q <= '0;
				bad_q <= 1'b0; nidx_q <= '0; nflags_q <= 2'b11; vidx_q <= '0;
				vchunk_q <= 1'b1; clen_q <= '0; cmode_q <= 1'b0; crem_q <= '0;
				hex_q <= 1'b0; bytes_q <= '0; seen_q <= 1'b0; err_q <= '0;
			end else begin
				phase_q <= ph; space_q <= sp; code_q <= cv; digits_q <= cd; bad_q <= cb;
				nidx_q <= ni; nflags_q <= nf; vidx_q <= vi; vchunk_q <= vc; clen_q <= cl;
				cmode_q <= cm; crem_q <= cr; hex_q <= hx; bytes_q <= bb; seen_q <= bs;
				err_q <= ec;
			end
		end
	end

endmodule
`default_nettype wire

FILE: hw/rtl/hrbe_out_queue.sv
`default_nettype none
module hrbe_out_queue (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              push0,
	input  wire hrbe_pkg::result_t din0,
	input  wire logic              push1,
	input  wire hrbe_pkg::result_t din1,
	output logic                   space_ok,
	output logic                   out_valid,
	input  wire logic              out_ready,
	output hrbe_pkg::result_t      dout
);

	hrbe_pkg::result_t slot_q [4];
	logic [1:0] rd_q, wr_q;
	logic [2:0] cnt_q;
	logic       pop;
	logic [1:0] npush;

	assign out_valid = cnt_q != 3'd0;
	assign dout      = slot_q[rd_q];
	assign pop       = out_valid && out_ready;
	assign npush     = 2'(push0) + 2'(push1);
	assign space_ok  = cnt_q <= 3'd2;

	always_ff @(posedge clk) begin
		if (push0) slot_q[wr_q] <= din0;
		if (push1) slot_q[wr_q + 2'd1] <= din1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_q <= '0; wr_q <= '0; cnt_q <= '0;
		end else begin
			if (pop) rd_q <= rd_q + 2'd1;
			wr_q  <= wr_q + npush;
			cnt_q <= cnt_q + 3'(npush) - 3'(pop);
		end
	end

endmodule
`default_nettype wire

FILE: hw/rtl/http_response_body_extractor_core.sv
// Throughput: one byte per cycle while s_axis_tready is high; the parser state
// updates once per accepted beat. A byte can yield two result beats, drained one
// per cycle from a four-entry queue while m_axis_tready is high. Reset (arst_n
// low) clears the parser to the status line and accepted_status to 200.
`default_nettype none
module http_response_body_extractor_core #(
	parameter int MAX_BODY_BYTES = 4096
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_axis_tvalid,
	output logic             s_axis_tready,
	input  wire logic [7:0]  s_axis_tdata,  // rx_byte
	input  wire logic        s_axis_tlast,  // end_of_response
	output logic             m_axis_tvalid,
	input  wire logic        m_axis_tready,
	output logic [31:0]      m_axis_tdata,  // body_byte, status_code, body_count, zero fill
	output logic [2:0]       m_axis_tuser,  // out_kind
	output logic             m_axis_tlast,  // last
	input  wire logic        cfg_valid,
	output logic             cfg_ready,
	input  wire logic [9:0]  cfg_data
);

	logic [9:0] status_q;
	logic       acc, v0, v1, space_ok;
	hrbe_pkg::result_t r0, r1, rq;

	assign cfg_ready     = 1'b1;
	assign s_axis_tready = space_ok;
	assign acc           = s_axis_tvalid && space_ok;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) status_q <= hrbe_pkg::STATUS_RESET;
		else if (cfg_valid) status_q <= cfg_data;
	end

	hrbe_parser #(.MAX_BODY_BYTES(MAX_BODY_BYTES)) u_parser (
		.clk(clk), .arst_n(arst_n), .in_valid(acc), .c(s_axis_tdata), .eor(s_axis_tlast),
		.accepted_status(status_q), .res0(r0), .res0_valid(v0), .res1(r1), .res1_valid(v1)
	);

	hrbe_out_queue u_queue (
		.clk(clk), .arst_n(arst_n), .push0(v0), .din0(r0), .push1(v1), .din1(r1),
		.space_ok(space_ok), .out_valid(m_axis_tvalid), .out_ready(m_axis_tready), .dout(rq)
	);

	assign m_axis_tdata = {1'b0, rq.body_count, rq.status_code, rq.body_byte};
	assign m_axis_tuser = rq.kind;
	assign m_axis_tlast = rq.last;

endmodule
`default_nettype wire

FILE: hw/rtl/hrbe_checker.sv
`default_nettype none
module hrbe_checker (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        m_axis_tvalid,
	input wire logic        m_axis_tready,
	input wire logic [31:0] m_axis_tdata,
	input wire logic [2:0]  m_axis_tuser,
	input wire logic        m_axis_tlast
);

	a_body_not_last: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tuser == hrbe_pkg::KIND_BODY |-> !m_axis_tlast)
		else $error("body beat marked last");

	a_term_last: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tuser != hrbe_pkg::KIND_BODY |-> m_axis_tlast)
		else $error("terminal beat not marked last");

	a_term_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tlast |-> m_axis_tdata[7:0] == 8'd0)
		else $error("terminal beat carries a byte");

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
		else $error("stalled result changed");

	a_kind: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> m_axis_tuser <= hrbe_pkg::KIND_OVERFLOW)
		else $error("unknown result kind");

endmodule

bind http_response_body_extractor_core hrbe_checker u_checker (
	.clk(clk), .arst_n(arst_n),
	.m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
	.m_axis_tdata(m_axis_tdata), .m_axis_tuser(m_axis_tuser), .m_axis_tlast(m_axis_tlast)
);
`default_nettype wire

FILE: tb/http_response_body_extractor_core_tb.sv
`default_nettype none
module http_response_body_extractor_core_tb;

	localparam int BODY_LIMIT = 4096;
	localparam int CYCLE_LIMIT = 20000;
	localparam logic [7:0] CR = 8'h0D;
	localparam logic [7:0] LF = 8'h0A;
	localparam logic [7:0] SP = 8'h20;
	localparam int NO_CHECK = -1;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic s_axis_tvalid = 1'b0;
	logic s_axis_tready;
	logic [7:0] s_axis_tdata = 8'h00;
	logic s_axis_tlast = 1'b0;
	logic m_axis_tvalid;
	logic m_axis_tready = 1'b0;
	logic [31:0] m_axis_tdata;
	logic [2:0] m_axis_tuser;
	logic m_axis_tlast;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [9:0] cfg_data = 10'd0;

	http_response_body_extractor_core #(.MAX_BODY_BYTES(BODY_LIMIT)) i_dut (
		.clk(clk), .arst_n(arst_n),
		.s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata), .s_axis_tlast(s_axis_tlast),
		.m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata), .m_axis_tuser(m_axis_tuser), .m_axis_tlast(m_axis_tlast),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// Parser state mirrored from the block.
	hrbe_pkg::phase_t ph;
	int unsigned spaces, code_val, code_digits, key_idx, key_flags, val_idx;
	int unsigned clen, chunk_left, nbody;
	bit code_bad, val_chunked, chunked, hex_seen, body_seen;
	logic [2:0] term_kind;
	logic [9:0] acc_status;

	hrbe_pkg::result_t body_results[$];
	int errors = 0;
	int cycles = 0;
	bit quiet = 1'b0;
	string cl_key = "content-length";
	string te_key = "transfer-encoding";
	string chunk_word = "chunked";

	function automatic logic [7:0] lc(logic [7:0] c);
		return (c >= "A" && c <= "Z") ? c + 8'd32 : c;
	endfunction

	function automatic bit is_ws(logic [7:0] c);
		return c == SP || (c >= 8'd9 && c <= 8'd13);
	endfunction

	function automatic bit is_dec(logic [7:0] c);
		return c >= "0" && c <= "9";
	endfunction

	function automatic int hex_of(logic [7:0] c);
		if (is_dec(c))
			return c - "0";
		if (lc(c) >= "a" && lc(c) <= "f")
			return lc(c) - "a" + 10;
		return -1;
	endfunction

	function void clear_parser();
		ph = hrbe_pkg::PH_STATUS; spaces = 0; code_val = 0; code_digits = 0; code_bad = 0;
		key_idx = 0; key_flags = 3; val_idx = 0; val_chunked = 1;
		clen = 0; chunked = 0; chunk_left = 0; hex_seen = 0;
		nbody = 0; body_seen = 0; term_kind = 3'd0;
	endfunction

	function int unsigned status_now();
		return (code_digits == 3 && !code_bad) ? code_val : 0;
	endfunction

	function void push_result(logic [2:0] kind, logic [7:0] b, logic lst);
		hrbe_pkg::result_t r;
		r.kind = kind; r.body_byte = b; r.status_code = 10'(status_now());
		r.body_count = nbody[12:0]; r.last = lst;
		body_results.push_back(r);
	endfunction

	function void stop_with(logic [2:0] kind);
		term_kind = kind;
		ph = hrbe_pkg::PH_DONE;
	endfunction

	function bit emit_body(logic [7:0] c);
		if (nbody >= BODY_LIMIT) begin
			stop_with(hrbe_pkg::KIND_OVERFLOW);
			return 0;
		end
		nbody++;
		body_seen = 1;
		push_result(hrbe_pkg::KIND_BODY, c, 1'b0);
		return 1;
	endfunction

	function void key_byte(logic [7:0] c);
		int unsigned f;
		if (c == CR) begin
			stop_with(hrbe_pkg::KIND_FORMAT);
		end else if (c == ":") begin
			f = 0;
			if (key_flags[0] && key_idx == 14) f |= 1;
			if (key_flags[1] && key_idx == 17) f |= 2;
			key_flags = f;
			val_idx = 0; val_chunked = 1;
			if (f[0]) clen = 0;
			ph = hrbe_pkg::PH_VAL_SKIP;
		end else begin
			if (key_idx >= 14 || lc(c) != cl_key[key_idx]) key_flags &= ~1;
			if (key_idx >= 17 || lc(c) != te_key[key_idx]) key_flags &= ~2;
			if (key_idx < 31) key_idx++;
		end
	endfunction

	function void value_char(logic [7:0] c);
		int unsigned d;
		if (c == CR) begin
			if (key_flags[1] && val_chunked && val_idx == 7) chunked = 1;
			ph = hrbe_pkg::PH_VAL_LF;
		end else if (key_flags[0]) begin
			if (val_idx == 0 && is_ws(c)) return;
			if (val_idx == 0 && c == "+") begin
				val_idx = 1;
				return;
			end
			if (val_idx <= 1 && is_dec(c)) begin
				d = c - "0";
				clen = (clen > (hrbe_pkg::LEN_SAT - d) / 10) ? hrbe_pkg::LEN_SAT :
					clen * 10 + d;
				val_idx = 1;
			end else begin
				val_idx = 2;
			end
		end else if (key_flags[1]) begin
			if (val_idx < 7 && lc(c) == chunk_word[val_idx]) val_idx++;
			else val_chunked = 0;
		end
	endfunction

	function void headers_done();
		bit ok;
		ok = status_now() != 0 && status_now() == acc_status;
		if (spaces == 0) stop_with(hrbe_pkg::KIND_FORMAT);
		else if (!ok) stop_with(hrbe_pkg::KIND_STATUS);
		else if (chunked) begin
			ph = hrbe_pkg::PH_CHUNK_SIZE; hex_seen = 0; chunk_left = 0;
		end else if (clen == 0) stop_with(hrbe_pkg::KIND_NO_BODY);
		else ph = hrbe_pkg::PH_BODY;
	endfunction

	function void parse_byte(logic [7:0] c, logic eor);
		int h;
		logic [2:0] kind;
		case (ph)
			hrbe_pkg::PH_STATUS: begin
				if (c == CR) ph = hrbe_pkg::PH_STATUS_LF;
				else if (c == SP) begin
					if (spaces < 2) spaces++;
				end else if (spaces == 1) begin
					if (is_dec(c)) begin
						if (code_digits < 3) code_val = code_val * 10 + (c - "0");
						if (code_digits < 4) code_digits++;
					end else code_bad = 1;
				end
			end
			hrbe_pkg::PH_STATUS_LF: ph = hrbe_pkg::PH_HDR_START;
			hrbe_pkg::PH_HDR_START: begin
				if (c == CR) ph = hrbe_pkg::PH_HDR_END_LF;
				else begin
					key_idx = 0; key_flags = 3; ph = hrbe_pkg::PH_KEY;
					key_byte(c);
				end
			end
			hrbe_pkg::PH_KEY: key_byte(c);
			hrbe_pkg::PH_VAL_SKIP: begin
				if (c != SP) begin
					ph = hrbe_pkg::PH_VALUE;
					value_char(c);
				end
			end
			hrbe_pkg::PH_VALUE: value_char(c);
			hrbe_pkg::PH_VAL_LF: begin
				if (c == LF) ph = hrbe_pkg::PH_HDR_START;
				else stop_with(hrbe_pkg::KIND_FORMAT);
			end
			hrbe_pkg::PH_HDR_END_LF: begin
				if (c == LF) headers_done();
				else stop_with(hrbe_pkg::KIND_FORMAT);
			end
			hrbe_pkg::PH_BODY: begin
				if (emit_body(c)) begin
					clen--;
					if (clen == 0) stop_with(hrbe_pkg::KIND_OK);
				end
			end
			hrbe_pkg::PH_CHUNK_SIZE: begin
				h = hex_of(c);
				if (!hex_seen) begin
					if (!is_ws(c)) begin
						if (h < 0)
							stop_with(body_seen ? hrbe_pkg::KIND_OK : hrbe_pkg::KIND_NO_BODY);
						else begin
							hex_seen = 1;
							chunk_left = h;
						end
					end
				end else if (h >= 0) begin
					chunk_left = (chunk_left > ((hrbe_pkg::LEN_SAT - h) >> 4)) ?
						hrbe_pkg::LEN_SAT : (chunk_left << 4) + h;
				end else if (chunk_left == 0) begin
					stop_with(body_seen ? hrbe_pkg::KIND_OK : hrbe_pkg::KIND_NO_BODY);
				end else begin
					ph = (c == CR) ? hrbe_pkg::PH_CHUNK_EXT_LF : hrbe_pkg::PH_CHUNK_EXT;
				end
			end
			hrbe_pkg::PH_CHUNK_EXT: if (c == CR) ph = hrbe_pkg::PH_CHUNK_EXT_LF;
			hrbe_pkg::PH_CHUNK_EXT_LF: begin
				if (c == LF) ph = hrbe_pkg::PH_CHUNK_DATA;
				else if (c != CR) ph = hrbe_pkg::PH_CHUNK_EXT;
			end
			hrbe_pkg::PH_CHUNK_DATA: begin
				if (emit_body(c)) begin
					chunk_left--;
					if (chunk_left == 0) ph = hrbe_pkg::PH_CHUNK_TRAIL1;
				end
			end
			hrbe_pkg::PH_CHUNK_TRAIL1: ph = hrbe_pkg::PH_CHUNK_TRAIL2;
			hrbe_pkg::PH_CHUNK_TRAIL2: begin
				ph = hrbe_pkg::PH_CHUNK_SIZE; hex_seen = 0; chunk_left = 0;
			end
			default: ;
		endcase
		if (eor) begin
			if (term_kind != 3'd0) kind = term_kind;
			else if (ph <= hrbe_pkg::PH_HDR_END_LF) kind = hrbe_pkg::KIND_FORMAT;
			else if (ph == hrbe_pkg::PH_BODY) kind = hrbe_pkg::KIND_OK;
			else kind = body_seen ? hrbe_pkg::KIND_OK : hrbe_pkg::KIND_NO_BODY;
			push_result(kind, 8'h00, 1'b1);
			clear_parser();
		end
	endfunction

	task automatic send_byte(input logic [7:0] c, input logic eor);
		while (!quiet && $urandom_range(99) < 19) begin
			s_axis_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= c;
		s_axis_tlast <= eor;
		@(posedge clk);
		while (!s_axis_tready) @(posedge clk);
		parse_byte(c, eor);
	endtask

	task automatic drain();
		s_axis_tvalid <= 1'b0;
		while (body_results.size() != 0) @(posedge clk);
		repeat (10) @(posedge clk);
	endtask

	task automatic write_status(input logic [9:0] v);
		cfg_valid <= 1'b1;
		cfg_data <= v;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		cfg_valid <= 1'b0;
		acc_status = v;
	endtask

	logic [7:0] resp[$];

	function automatic void add_text(string s);
		for (int i = 0; i < s.len(); i++) resp.push_back(s[i]);
	endfunction

	function automatic string mix_case(string s);
		string r;
		r = s;
		for (int i = 0; i < r.len(); i++)
			if ($urandom_range(1) && r[i] >= "a" && r[i] <= "z") r[i] = r[i] - 8'd32;
		return r;
	endfunction

	// Builds one response, mostly well formed, sometimes broken or pure noise.
	function automatic void build_response(int big_len);
		int sel, n, len;
		bit use_chunks;
		resp.delete();
		sel = $urandom_range(99);
		if (sel < 6) begin
			n = $urandom_range(12, 1);
			repeat (n) resp.push_back(8'($urandom_range(255)));
			return;
		end
		if ($urandom_range(99) < 4) add_text("HTTP/1.1\r\n");
		else begin
			add_text("HTTP/1.1 ");
			case ($urandom_range(9))
				0: add_text($sformatf("%0d", $urandom_range(999)));
				1: add_text("2x0");
				default: add_text($sformatf("%0d", acc_status));
			endcase
			add_text(" OK\r\n");
		end
		resp.push_back(8'($urandom_range(255)));
		use_chunks = $urandom_range(2) == 0;
		len = big_len > 0 ? big_len : $urandom_range(20);
		n = $urandom_range(3);
		for (int i = 0; i < n; i++)
			case ($urandom_range(5))
				0: add_text("X-Tag:  v\r\n");
				1: add_text("bad line\r\n");
				2: add_text("Content-Length: 9\r\n");
				3: add_text("Host: a\rZ");
				default: add_text(mix_case("Transfer-Encoding: chunk\r\n"));
			endcase
		if (use_chunks) add_text({mix_case("transfer-encoding:  chunked"), "\r\n"});
		else add_text($sformatf("%s: %s%0d\r\n", mix_case("content-length"),
			$urandom_range(3) == 0 ? "+" : "", len));
		add_text("\r\n");
		if (use_chunks) begin
			n = $urandom_range(3);
			for (int k = 0; k < n; k++) begin
				len = $urandom_range(12, 1);
				add_text($sformatf(" %0h%s\r\n", len, $urandom_range(3) == 0 ? ";x=1" : ""));
				repeat (len) resp.push_back(8'($urandom_range(255)));
				add_text("\r\n");
			end
			add_text($urandom_range(3) == 0 ? "zz\r\n" : "0\r\n\r\n");
		end else begin
			repeat (len) resp.push_back(8'($urandom_range(255)));
		end
		if ($urandom_range(9) == 0) begin
			n = $urandom_range(resp.size(), 1);
			while (resp.size() > n) void'(resp.pop_back());
		end
	endfunction

	task automatic send_responses(input int nbytes);
		int sent;
		sent = 0;
		while (sent < nbytes) begin
			build_response(0);
			foreach (resp[i]) send_byte(resp[i], i == resp.size() - 1);
			sent += resp.size();
		end
	endtask

	typedef struct {
		logic [7:0] c;
		logic eor;
		int kind;
	} row_t;

	row_t rows[] = '{
		'{"H", 1'b0, NO_CHECK}, '{SP, 1'b0, NO_CHECK}, '{"2", 1'b0, NO_CHECK},
		'{"0", 1'b0, NO_CHECK}, '{"0", 1'b0, NO_CHECK}, '{CR, 1'b0, NO_CHECK},
		'{8'hFF, 1'b0, NO_CHECK}, '{CR, 1'b0, NO_CHECK}, '{LF, 1'b0, NO_CHECK},
		'{8'h00, 1'b1, hrbe_pkg::KIND_NO_BODY},
		'{CR, 1'b1, hrbe_pkg::KIND_FORMAT},
		'{SP, 1'b0, NO_CHECK}, '{"5", 1'b0, NO_CHECK}, '{CR, 1'b0, NO_CHECK},
		'{LF, 1'b0, NO_CHECK}, '{CR, 1'b0, NO_CHECK}, '{LF, 1'b0, NO_CHECK},
		'{"x", 1'b1, hrbe_pkg::KIND_STATUS},
		'{"H", 1'b0, NO_CHECK}, '{CR, 1'b0, NO_CHECK}, '{LF, 1'b0, NO_CHECK},
		'{CR, 1'b0, NO_CHECK}, '{LF, 1'b0, NO_CHECK}, '{"q", 1'b1, hrbe_pkg::KIND_FORMAT}
	};

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("tb: failure");
			$finish;
		end
	end

	always @(posedge clk)
		m_axis_tready <= quiet ? 1'b1 : ($urandom_range(99) >= 19);

	always @(posedge clk) begin
		hrbe_pkg::result_t got, want;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			got.kind = m_axis_tuser;
			got.body_byte = m_axis_tdata[7:0];
			got.status_code = m_axis_tdata[17:8];
			got.body_count = m_axis_tdata[30:18];
			got.last = m_axis_tlast;
			if (body_results.size() == 0) begin
				$display("%0t: expected no beat, actual kind %0d", $realtime, got.kind);
				errors++;
			end else begin
				want = body_results.pop_front();
				if (got !== want || m_axis_tdata[31] !== 1'b0) begin
					$display("%0t: expected kind %0d byte %02h status %0d count %0d last %0d",
						$realtime, want.kind, want.body_byte, want.status_code,
						want.body_count, want.last);
					$display("%0t: actual   kind %0d byte %02h status %0d count %0d last %0d pad %b",
						$realtime, got.kind, got.body_byte, got.status_code,
						got.body_count, got.last, m_axis_tdata[31]);
					errors++;
				end
			end
		end
	end

	initial begin
		acc_status = hrbe_pkg::STATUS_RESET;
		clear_parser();
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		foreach (rows[i]) begin
			send_byte(rows[i].c, rows[i].eor);
			if (rows[i].kind != NO_CHECK && body_results[$].kind != rows[i].kind) begin
				$display("%0t: expected kind %0d, predicted %0d", $realtime,
					rows[i].kind, body_results[$].kind);
				errors++;
			end
		end
		send_responses(100);
		drain();
		write_status(10'd999);
		send_responses(100);
		drain();
		write_status(10'd100);
		quiet = 1'b1;
		send_responses(100);
		drain();
		quiet = 1'b0;
		write_status(10'd404);
		send_responses(100);
		drain();
		write_status(hrbe_pkg::STATUS_RESET);
		send_responses(100);
		drain();
		if (errors == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end
endmodule
`default_nettype wire

FILE: http_response_body_extractor_core.f
hw/rtl/hrbe_pkg.sv
hw/rtl/hrbe_parser.sv
hw/rtl/hrbe_out_queue.sv
hw/rtl/http_response_body_extractor_core.sv
hw/rtl/hrbe_checker.sv
tb/http_response_body_extractor_core_tb.sv
